[rtl/cpsc_pkg.sv]
// Package: item types, ROM contents and helpers for the codon pair substitution counter.
`default_nettype none
package cpsc_pkg;

  localparam int unsigned MaxBases = 65536;
  localparam int unsigned BaseCapHw = 131071;
  localparam logic [16:0] BASE_CAP =
      (MaxBases < BaseCapHw) ? 17'(MaxBases) : 17'(BaseCapHw);
  localparam logic [14:0] CNT_MAX = 15'h7FFF;
  localparam logic [21:0] SUM_MAX = 22'h3FFFFF;

  localparam logic [2:0] GAP_CODE = 3'd4;

  typedef struct packed {
    logic [7:0] base_a;
    logic [7:0] base_b;
    logic       last_base;
  } in_item_t;

  typedef struct packed {
    logic [16:0] aligned_bases;
    logic [14:0] codons_used;
    logic [14:0] codons_gapped;
    logic [14:0] codons_stopped;
    logic [14:0] fourfold_sites;
    logic [14:0] fourfold_transitions;
    logic [14:0] fourfold_transversions;
    logic [21:0] syn_sites_x60;
    logic [21:0] syn_transitions_x60;
    logic [21:0] syn_transversions_x60;
    logic [21:0] nonsyn_transitions_x60;
    logic [21:0] nonsyn_transversions_x60;
  } out_item_t;

  // Codon control passed from the front end to the accumulator
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       codon;
    logic       gap;
    logic [5:0] c1;
    logic [5:0] c2;
  } codon_ctl_t;

  localparam string GenCode =
      "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

  function automatic logic [7:0] aa_of(input logic [5:0] c);
    return GenCode[c];
  endfunction

  function automatic logic stop_of(input logic [5:0] c);
    return aa_of(c) == "*";
  endfunction

  function automatic logic is_ts(input logic [1:0] x, input logic [1:0] y);
    return (x ^ y) == 2'd2;
  endfunction

  function automatic logic [2:0] encode(input logic [7:0] ch);
    logic [2:0] r;
    case (ch)
      "A", "a": r = 3'd0;
      "C", "c": r = 3'd1;
      "G", "g": r = 3'd2;
      "T", "t", "U", "u": r = 3'd3;
      default: r = GAP_CODE;
    endcase
    return r;
  endfunction

  // bits 3..0 synonymous neighbours, bit 4 stop, bit 5 fourfold third
  function automatic logic [9:0] codon_info(input logic [5:0] c);
    logic [3:0] cnt;
    logic [5:0] cc;
    logic [5:0] first;
    logic       ff;
    cnt = '0;
    if (!stop_of(c)) begin
      for (int p = 0; p < 3; p++) begin
        for (int a = 0; a < 4; a++) begin
          cc = c;
          cc[4-2*p +: 2] = 2'(a);
          if (cc != c && !stop_of(cc) && aa_of(cc) == aa_of(c)) begin
            cnt = cnt + 4'd1;
          end
        end
      end
    end
    first = c & 6'h3C;
    ff = !stop_of(first);
    for (int x = 0; x < 4; x++) begin
      cc = first | 6'(x);
      if (stop_of(cc) || aa_of(cc) != aa_of(first)) begin
        ff = 1'b0;
      end
    end
    return {4'd0, ff, stop_of(c), cnt};
  endfunction

  function automatic logic [31:0] pair_entry(input logic [5:0] c1, input logic [5:0] c2);
    int n1[3];
    int n2[3];
    int diff[3];
    int cur[3];
    int nd, npaths, valid, k, pos, cls, scale;
    int tot[4];
    int cnt[4];
    int ord[3];
    logic [5:0] cur_c, nc;
    logic ok;
    logic [31:0] r;
    nd = 0; valid = 0;
    for (int j = 0; j < 4; j++) tot[j] = 0;
    r = '0;
    if (c1 != c2 && !stop_of(c1) && !stop_of(c2)) begin
      for (int p = 0; p < 3; p++) begin
        n1[p] = int'(c1[4-2*p +: 2]);
        n2[p] = int'(c2[4-2*p +: 2]);
        if (n1[p] != n2[p]) begin
          diff[nd] = p;
          nd++;
        end
      end
      npaths = (nd == 1) ? 1 : (nd == 2) ? 2 : 6;
      for (int pi = 0; pi < npaths; pi++) begin
        case (pi)
          0: ord = '{0, 1, 2};
          1: begin
            if (nd == 2) ord = '{1, 0, 2};
            else ord = '{0, 2, 1};
          end
          2: ord = '{1, 0, 2};
          3: ord = '{1, 2, 0};
          4: ord = '{2, 0, 1};
          default: ord = '{2, 1, 0};
        endcase
        for (int j = 0; j < 3; j++) cur[j] = n1[j];
        for (int j = 0; j < 4; j++) cnt[j] = 0;
        cur_c = c1;
        ok = 1'b1;
        for (int j = 0; j < 3; j++) begin
          if (j < nd && ok) begin
            k = ord[j];
            pos = diff[k];
            cls = is_ts(2'(cur[pos]), 2'(n2[pos])) ? 0 : 1;
            cur[pos] = n2[pos];
            nc = {2'(cur[0]), 2'(cur[1]), 2'(cur[2])};
            if (stop_of(nc)) begin
              ok = 1'b0;
            end else begin
              if (aa_of(cur_c) != aa_of(nc)) cls = cls + 2;
              cnt[cls]++;
              cur_c = nc;
            end
          end
        end
        if (ok) begin
          valid++;
          for (int j = 0; j < 4; j++) tot[j] += cnt[j];
        end
      end
      // 60 over one to six paths is a whole number
      case (valid)
        1: scale = 60;
        2: scale = 30;
        3: scale = 20;
        4: scale = 15;
        5: scale = 12;
        default: scale = 10;
      endcase
      if (valid != 0) begin
        for (int j = 0; j < 4; j++) r[8*j +: 8] = 8'(tot[j] * scale);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/codon_pair_substitution_counter.sv]
// Top level: codon pair substitution counter.
`default_nettype none
// Usage:
//   in  channel: one aligned base pair per item (base_a, base_b, last_base).
//   out channel: one item of totals for each input item with last_base set.
//   Items without last_base are taken one per cycle while in_stall is low. Each
//   last item reserves a result buffer entry from acceptance, so even with the
//   receiver ready a run of last items is taken in pairs, with in_stall high between pairs.
//   Stage 1 encodes bases and assembles codons; stage 2 reads the codon info
//   and pair substitution ROMs (synchronous); stage 3 adds into the saturating
//   counters held in registers and, on the last item, loads the result buffer
//   and clears. A result is offered once its last item has passed stages 1 to
//   3 and been written into the result buffer.
//   Results go through a two-entry buffer; while the receiver stalls, the
//   input keeps flowing until buffered plus in-flight results reach two,
//   then in_stall rises.
//   Reset (rst, synchronous) clears all counts, the codon phase and the
//   result buffer; the ROMs hold fixed contents and need no clearing pass.
//   Counters hold at their maximum; a trailing partial codon is ignored.
module codon_pair_substitution_counter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cpsc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cpsc_pkg::out_item_t  out_item
);
  import cpsc_pkg::*;

  logic       take;
  codon_ctl_t c1s;
  logic [16:0] bases1;

  cpsc_front u_front (
    .clk(clk), .rst(rst), .take(take), .item(in_item), .ctl(c1s), .bases(bases1)
  );

  // ROMs as synchronous memories
  logic [9:0]  info_rom [64];
  logic [31:0] pair_rom [4096];
  always_comb begin
    for (int i = 0; i < 64; i++) info_rom[i] = codon_info(6'(i));
  end
  always_comb begin
    for (int i = 0; i < 4096; i++) pair_rom[i] = pair_entry(6'(i >> 6), 6'(i));
  end

  codon_ctl_t  c2s;
  logic [16:0] bases2;
  logic [9:0]  i1, i2;
  logic [31:0] pe;

  always_ff @(posedge clk) begin
    i1 <= info_rom[c1s.c1];
    i2 <= info_rom[c1s.c2];
    pe <= pair_rom[{c1s.c1, c1s.c2}];
    bases2 <= bases1;
    c2s.last <= c1s.last;
    c2s.codon <= c1s.codon;
    c2s.gap <= c1s.gap;
    c2s.c1 <= c1s.c1;
    c2s.c2 <= c1s.c2;
    if (rst) c2s.valid <= 1'b0;
    else c2s.valid <= c1s.valid;
  end

  // Accumulate
  logic [14:0] cnt [6];
  logic [21:0] sums [5];
  logic [14:0] cnt_next [6];
  logic [21:0] sums_next [5];
  logic [7:0]  add_s [5];
  logic        inc [6];
  logic        used, ff;

  function automatic logic [14:0] sat_c(input logic [14:0] v, input logic a);
    return (a && v != CNT_MAX) ? v + 15'd1 : v;
  endfunction
  function automatic logic [21:0] sat_s(input logic [21:0] v, input logic [7:0] a);
    logic [22:0] s;
    s = {1'b0, v} + 23'(a);
    return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[21:0];
  endfunction

  always_comb begin
    used = c2s.codon && !c2s.gap && !(i1[4] | i2[4]);
    ff = used && i1[5] && i2[5] && (c2s.c1[5:2] == c2s.c2[5:2]);
    inc[0] = used;
    inc[1] = c2s.codon && c2s.gap;
    inc[2] = c2s.codon && !c2s.gap && (i1[4] | i2[4]);
    inc[3] = ff;
    inc[4] = ff && (c2s.c1[1:0] != c2s.c2[1:0]) && is_ts(c2s.c1[1:0], c2s.c2[1:0]);
    inc[5] = ff && (c2s.c1[1:0] != c2s.c2[1:0]) && !is_ts(c2s.c1[1:0], c2s.c2[1:0]);
    add_s[0] = used ? 8'({4'd0, i1[3:0]} + {4'd0, i2[3:0]}) * 8'd10 : 8'd0;
    for (int j = 0; j < 4; j++) add_s[j+1] = used ? pe[8*j +: 8] : 8'd0;
    for (int j = 0; j < 6; j++) cnt_next[j] = sat_c(cnt[j], inc[j]);
    for (int j = 0; j < 5; j++) sums_next[j] = sat_s(sums[j], add_s[j]);
  end

  // Two-entry result buffer
  out_item_t buf_q [2];
  logic [1:0] fill;
  logic       rd, wr;
  logic [1:0] inflight;
  out_item_t  res;

  assign res = '{aligned_bases: bases2, codons_used: cnt_next[0],
      codons_gapped: cnt_next[1], codons_stopped: cnt_next[2],
      fourfold_sites: cnt_next[3], fourfold_transitions: cnt_next[4],
      fourfold_transversions: cnt_next[5], syn_sites_x60: sums_next[0],
      syn_transitions_x60: sums_next[1], syn_transversions_x60: sums_next[2],
      nonsyn_transitions_x60: sums_next[3], nonsyn_transversions_x60: sums_next[4]};

  assign wr = c2s.valid && c2s.last;
  assign out_valid = (fill != 2'd0);
  assign out_item = buf_q[0];
  assign rd = out_valid && !out_stall;
  // last items still in the pipe need room too
  assign inflight = 2'(c1s.valid && c1s.last) + 2'(c2s.valid && c2s.last);
  assign in_stall = (3'(fill) + 3'(inflight)) >= 3'd2;
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 6; j++) cnt[j] <= '0;
      for (int j = 0; j < 5; j++) sums[j] <= '0;
      fill <= '0;
    end else begin
      if (c2s.valid) begin
        for (int j = 0; j < 6; j++) cnt[j] <= c2s.last ? 15'd0 : cnt_next[j];
        for (int j = 0; j < 5; j++) sums[j] <= c2s.last ? 22'd0 : sums_next[j];
      end
      fill <= fill + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && (fill == 2'd0 || (fill == 2'd1 && rd))) buf_q[0] <= res;
    else if (rd) buf_q[0] <= buf_q[1];
    if (wr && ((fill == 2'd1 && !rd) || (fill == 2'd2 && rd))) buf_q[1] <= res;
  end
endmodule
`default_nettype wire

[rtl/cpsc_front.sv]
// Front end: base encoding, codon assembly and base counting.
`default_nettype none
module cpsc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  cpsc_pkg::in_item_t item,
  output cpsc_pkg::codon_ctl_t ctl,
  output logic [16:0]       bases
);
  import cpsc_pkg::*;

  logic [1:0]  phase;
  logic [4:0]  part_a, part_b;
  logic [16:0] base_cnt;
  logic [2:0]  na, nb;
  logic [16:0] base_cnt_next;
  logic [4:0]  pa0, pb0;

  assign na = encode(item.base_a);
  assign nb = encode(item.base_b);
  assign base_cnt_next = (base_cnt < BASE_CAP) ? base_cnt + 17'd1 : base_cnt;
  assign pa0 = (phase == 2'd0) ? 5'd0 : part_a;
  assign pb0 = (phase == 2'd0) ? 5'd0 : part_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      part_a <= '0;
      part_b <= '0;
      base_cnt <= '0;
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= take;
      if (take) begin
        ctl.last  <= item.last_base;
        ctl.codon <= (phase == 2'd2);
        ctl.gap   <= part_a[4] | part_b[4] | na[2] | nb[2];
        ctl.c1    <= {part_a[3:0], na[1:0]};
        ctl.c2    <= {part_b[3:0], nb[1:0]};
        bases     <= base_cnt_next;
        if (item.last_base) begin
          phase <= '0;
          part_a <= '0;
          part_b <= '0;
          base_cnt <= '0;
        end else begin
          base_cnt <= base_cnt_next;
          if (phase == 2'd2) begin
            phase <= '0;
          end else begin
            phase <= phase + 2'd1;
            part_a <= {pa0[4] | na[2], pa0[1:0], na[1:0]};
            part_b <= {pb0[4] | nb[2], pb0[1:0], nb[1:0]};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire
